FILE: design/sscb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscb_pkg
// Shared types and constants of the spherical shell cell binner.
// ----------------------------------------------------------------------------
package sscb_pkg;

   localparam int unsigned CORDIC_STEPS = 30;
   localparam int unsigned NORM_STAGES  = 6;
   localparam int unsigned CORDIC_LAT   = NORM_STAGES + CORDIC_STEPS + 2;
   localparam int unsigned ISQRT_LAT    = 32;
   localparam int unsigned SB_LEN       = ISQRT_LAT + CORDIC_LAT;

   localparam logic [30:0] CELL_COUNT = 31'd1048576;
   localparam logic [10:0] MAX_BINS   = 11'd1024;

   localparam logic [2:0] REG_CENTER_X    = 3'd0;
   localparam logic [2:0] REG_CENTER_Y    = 3'd1;
   localparam logic [2:0] REG_CENTER_Z    = 3'd2;
   localparam logic [2:0] REG_DIAMETER    = 3'd3;
   localparam logic [2:0] REG_THICKNESS   = 3'd4;
   localparam logic [2:0] REG_THETA_BINS  = 3'd5;
   localparam logic [2:0] REG_PHI_BINS    = 3'd6;

   localparam logic [31:0] ANGLE_QUARTER = 32'h4000_0000;
   localparam logic [31:0] ANGLE_HALF    = 32'h8000_0000;

   typedef struct packed {
      logic        keep;
      logic [19:0] idx;
      logic [30:0] dx;
      logic [30:0] dy;
      logic [30:0] dz;
      logic        rho_zero;
   } sb_type;

   function automatic logic [31:0] step_angle(input logic [4:0] i);
      logic [31:0] a;
      case (i)
         5'd0:  a = 32'd536870912;
         5'd1:  a = 32'd316933406;
         5'd2:  a = 32'd167458907;
         5'd3:  a = 32'd85004756;
         5'd4:  a = 32'd42667331;
         5'd5:  a = 32'd21354465;
         5'd6:  a = 32'd10679838;
         5'd7:  a = 32'd5340245;
         5'd8:  a = 32'd2670163;
         5'd9:  a = 32'd1335087;
         5'd10: a = 32'd667544;
         5'd11: a = 32'd333772;
         5'd12: a = 32'd166886;
         5'd13: a = 32'd83443;
         5'd14: a = 32'd41722;
         5'd15: a = 32'd20861;
         5'd16: a = 32'd10430;
         5'd17: a = 32'd5215;
         5'd18: a = 32'd2608;
         5'd19: a = 32'd1304;
         5'd20: a = 32'd652;
         5'd21: a = 32'd326;
         5'd22: a = 32'd163;
         5'd23: a = 32'd81;
         5'd24: a = 32'd41;
         5'd25: a = 32'd20;
         5'd26: a = 32'd10;
         5'd27: a = 32'd5;
         5'd28: a = 32'd3;
         5'd29: a = 32'd1;
         default: a = 32'd0;
      endcase
      return a;
   endfunction

endpackage

FILE: design/sscb_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscb_isqrt
// Pipelined floor square root of a 64-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module sscb_isqrt (
   input  logic        clock,
   input  logic        enable,
   input  logic [63:0] radicand,
   output logic [31:0] root
);
   import sscb_pkg::*;

   logic [63:0] v_ff   [ISQRT_LAT];
   logic [63:0] res_ff [ISQRT_LAT];

   genvar j;
   generate
      for (j = 0; j < ISQRT_LAT; j++) begin : g_stage
         localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
         logic [63:0] v_src;
         logic [63:0] res_src;
         logic [63:0] trial;
         if (j == 0) begin : g_first
            assign v_src   = radicand;
            assign res_src = 64'd0;
         end else begin : g_next
            assign v_src   = v_ff[j-1];
            assign res_src = res_ff[j-1];
         end
         assign trial = res_src + BIT;
         always_ff @(posedge clock) begin
            if (enable) begin
               if (v_src >= trial) begin
                  v_ff[j]   <= v_src - trial;
                  res_ff[j] <= (res_src >> 1) + BIT;
               end else begin
                  v_ff[j]   <= v_src;
                  res_ff[j] <= res_src >> 1;
               end
            end
         end
      end
   endgenerate

   assign root = res_ff[ISQRT_LAT-1][31:0];

endmodule

FILE: design/sscb_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscb_cordic
// Pipelined vectoring CORDIC: angle of (x,y), y > 0, in binary turns,
// with operand normalization and half-plane clamp.
// ----------------------------------------------------------------------------
module sscb_cordic (
   input  logic        clock,
   input  logic        enable,
   input  logic [32:0] x_in,
   input  logic [32:0] y_in,
   output logic [31:0] angle
);
   import sscb_pkg::*;

   logic signed [63:0] na_ff [NORM_STAGES+1];
   logic signed [63:0] nb_ff [NORM_STAGES+1];
   logic        [63:0] nm_ff [NORM_STAGES+1];
   logic signed [63:0] ca_ff [CORDIC_STEPS];
   logic signed [63:0] cb_ff [CORDIC_STEPS];
   logic        [31:0] z_ff  [CORDIC_STEPS];
   logic        [31:0] angle_ff;

   logic signed [63:0] a0;
   logic signed [63:0] b0;
   logic        [63:0] bmag;
   logic        [31:0] zl;

   assign a0   = $signed({31'd0, y_in});
   assign b0   = -$signed({{31{x_in[32]}}, x_in});
   assign bmag = b0[63] ? 64'(-b0) : 64'(b0);

   always_ff @(posedge clock) begin
      if (enable) begin
         na_ff[0] <= a0;
         nb_ff[0] <= b0;
         nm_ff[0] <= (bmag > 64'(a0)) ? bmag : 64'(a0);
      end
   end

   genvar k, i;
   generate
      for (k = 1; k <= NORM_STAGES; k++) begin : g_norm
         localparam int unsigned SH = 1 << (NORM_STAGES - k);
         localparam logic [63:0] LIM = 64'd1 << (61 - SH);
         always_ff @(posedge clock) begin
            if (enable) begin
               if (nm_ff[k-1] < LIM) begin
                  na_ff[k] <= na_ff[k-1] <<< SH;
                  nb_ff[k] <= nb_ff[k-1] <<< SH;
                  nm_ff[k] <= nm_ff[k-1] << SH;
               end else begin
                  na_ff[k] <= na_ff[k-1];
                  nb_ff[k] <= nb_ff[k-1];
                  nm_ff[k] <= nm_ff[k-1];
               end
            end
         end
      end

      for (i = 0; i < CORDIC_STEPS; i++) begin : g_step
         localparam logic [31:0] STEP = step_angle(5'(i));
         logic signed [63:0] a_src;
         logic signed [63:0] b_src;
         logic        [31:0] z_src;
         if (i == 0) begin : g_first
            assign a_src = na_ff[NORM_STAGES];
            assign b_src = nb_ff[NORM_STAGES];
            assign z_src = ANGLE_QUARTER;
         end else begin : g_next
            assign a_src = ca_ff[i-1];
            assign b_src = cb_ff[i-1];
            assign z_src = z_ff[i-1];
         end
         always_ff @(posedge clock) begin
            if (enable) begin
               if (!b_src[63]) begin
                  ca_ff[i] <= a_src + (b_src >>> i);
                  cb_ff[i] <= b_src - (a_src >>> i);
                  z_ff[i]  <= z_src + STEP;
               end else begin
                  ca_ff[i] <= a_src - (b_src >>> i);
                  cb_ff[i] <= b_src + (a_src >>> i);
                  z_ff[i]  <= z_src - STEP;
               end
            end
         end
      end
   endgenerate

   assign zl = z_ff[CORDIC_STEPS-1];

   always_ff @(posedge clock) begin
      if (enable) begin
         if (zl == 32'd0 || zl >= 32'hC000_0000) begin
            angle_ff <= 32'd1;
         end else if (zl >= ANGLE_HALF) begin
            angle_ff <= 32'h7FFF_FFFF;
         end else begin
            angle_ff <= zl;
         end
      end
   end

   assign angle = angle_ff;

endmodule

FILE: design/spherical_shell_cell_binner_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spherical_shell_cell_binner_unit
// Keeps mesh cells inside a spherical shell and bins their direction.
//
// Input channel req_*: one cell index and centre (signed Q16.16) per
// transfer. Result channel rsp_*: one transfer per kept cell carrying the
// cell index, azimuth bin and polar bin, in input order. Dropped cells
// give no transfer.
// Configuration port csr_*: register writes, which the user must make only
// while the unit is idle; the unit itself does not enforce this.
// Throughput: one cell per cycle while the result channel is not stalled.
// Pipeline: a cell passes the four front subtract/square/sum stages, the
// 32-stage square root, the 38-stage angle pipeline and two output stages;
// the first of these 76 stages loads at the input transfer edge.
// Reset: clears all valid bits and loads the register defaults.
// Stall: while a result waits and rsp_ready is low, the whole pipeline
// holds and req_ready is low; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module spherical_shell_cell_binner_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [19:0] req_cell_index,
   input  logic [31:0] req_cell_x,
   input  logic [31:0] req_cell_y,
   input  logic [31:0] req_cell_z,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [19:0] rsp_shell_cell,
   output logic [9:0]  rsp_azimuth_bin,
   output logic [10:0] rsp_polar_bin,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import sscb_pkg::*;

   function automatic logic [10:0] bins_clamp(input logic [10:0] r);
      logic [10:0] c;
      if (r == 11'd0) c = 11'd1;
      else if (r > MAX_BINS) c = MAX_BINS;
      else c = r;
      return c;
   endfunction

   function automatic logic in_lim(input logic [32:0] d);
      return (d[32:30] == 3'b000) || (d[32:30] == 3'b111 && d[29:0] != 30'd0);
   endfunction

   // configuration
   logic [31:0] cx_ff, cy_ff, cz_ff;
   logic [30:0] diam_ff, thick_ff;
   logic [10:0] tbins_ff, pbins_ff;
   logic [61:0] dsq_ff, isq_ff;
   logic        inner_pos_ff;
   logic [10:0] nt_ff, np_ff;
   logic signed [32:0] inner;

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff    <= 32'd0;
         cy_ff    <= 32'd0;
         cz_ff    <= 32'd0;
         diam_ff  <= 31'd65536;
         thick_ff <= 31'd0;
         tbins_ff <= 11'd32;
         pbins_ff <= 11'd16;
      end else if (csr_write) begin
         case (csr_index)
            REG_CENTER_X:   cx_ff    <= csr_wdata;
            REG_CENTER_Y:   cy_ff    <= csr_wdata;
            REG_CENTER_Z:   cz_ff    <= csr_wdata;
            REG_DIAMETER:   diam_ff  <= csr_wdata[30:0];
            REG_THICKNESS:  thick_ff <= csr_wdata[30:0];
            REG_THETA_BINS: tbins_ff <= csr_wdata[10:0];
            REG_PHI_BINS:   pbins_ff <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   assign inner = $signed({2'b00, diam_ff}) - $signed({1'b0, thick_ff, 1'b0});

   always_ff @(posedge clock) begin
      dsq_ff       <= {31'd0, diam_ff} * {31'd0, diam_ff};
      isq_ff       <= {31'd0, inner[30:0]} * {31'd0, inner[30:0]};
      inner_pos_ff <= !inner[32] && (inner != 33'sd0);
      nt_ff        <= bins_clamp(tbins_ff);
      np_ff        <= bins_clamp(pbins_ff);
   end

   logic adv;
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // front: offset, squares, sums
   logic [32:0] dx_w, dy_w, dz_w;
   assign dx_w = {req_cell_x[31], req_cell_x} - {cx_ff[31], cx_ff};
   assign dy_w = {req_cell_y[31], req_cell_y} - {cy_ff[31], cy_ff};
   assign dz_w = {req_cell_z[31], req_cell_z} - {cz_ff[31], cz_ff};

   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   logic        ok1_ff, ok2_ff, ok3_ff, ok4_ff;
   logic [19:0] idx1_ff, idx2_ff, idx3_ff, idx4_ff;
   logic [30:0] dx1_ff, dy1_ff, dz1_ff, dx2_ff, dy2_ff, dz2_ff;
   logic [30:0] dx3_ff, dy3_ff, dz3_ff, dx4_ff, dy4_ff, dz4_ff;
   logic [59:0] sx2_ff, sy2_ff, sz2_ff, sz3_ff;
   logic [60:0] rho3_ff, rho4_ff;
   logic [61:0] r24_ff;
   logic [29:0] mx, my, mz;

   assign mx = dx1_ff[30] ? 30'(-dx1_ff) : dx1_ff[29:0];
   assign my = dy1_ff[30] ? 30'(-dy1_ff) : dy1_ff[29:0];
   assign mz = dz1_ff[30] ? 30'(-dz1_ff) : dz1_ff[29:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ok1_ff  <= ({11'd0, req_cell_index} < CELL_COUNT)
                    && in_lim(dx_w) && in_lim(dy_w) && in_lim(dz_w);
         idx1_ff <= req_cell_index;
         dx1_ff  <= dx_w[30:0];
         dy1_ff  <= dy_w[30:0];
         dz1_ff  <= dz_w[30:0];

         ok2_ff  <= ok1_ff;
         idx2_ff <= idx1_ff;
         dx2_ff  <= dx1_ff;
         dy2_ff  <= dy1_ff;
         dz2_ff  <= dz1_ff;
         sx2_ff  <= {30'd0, mx} * {30'd0, mx};
         sy2_ff  <= {30'd0, my} * {30'd0, my};
         sz2_ff  <= {30'd0, mz} * {30'd0, mz};

         ok3_ff  <= ok2_ff;
         idx3_ff <= idx2_ff;
         dx3_ff  <= dx2_ff;
         dy3_ff  <= dy2_ff;
         dz3_ff  <= dz2_ff;
         rho3_ff <= {1'b0, sx2_ff} + {1'b0, sy2_ff};
         sz3_ff  <= sz2_ff;

         ok4_ff  <= ok3_ff;
         idx4_ff <= idx3_ff;
         dx4_ff  <= dx3_ff;
         dy4_ff  <= dy3_ff;
         dz4_ff  <= dz3_ff;
         rho4_ff <= rho3_ff;
         r24_ff  <= {1'b0, rho3_ff} + {2'b00, sz3_ff};
      end
   end

   // shell test and sideband line
   logic [63:0] four_r2;
   sb_type      sb_in;
   assign four_r2 = {r24_ff, 2'b00};

   always_comb begin
      sb_in.keep     = ok4_ff && (four_r2 <= {2'b00, dsq_ff})
                       && !(inner_pos_ff && four_r2 < {2'b00, isq_ff});
      sb_in.idx      = idx4_ff;
      sb_in.dx       = dx4_ff;
      sb_in.dy       = dy4_ff;
      sb_in.dz       = dz4_ff;
      sb_in.rho_zero = (rho4_ff == 61'd0);
   end

   logic   sbv_ff [SB_LEN];
   sb_type sb_ff  [SB_LEN];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < SB_LEN; n++) sbv_ff[n] <= 1'b0;
      end else if (adv) begin
         sbv_ff[0] <= v4_ff;
         for (int n = 1; n < SB_LEN; n++) sbv_ff[n] <= sbv_ff[n-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sb_ff[0] <= sb_in;
         for (int n = 1; n < SB_LEN; n++) sb_ff[n] <= sb_ff[n-1];
      end
   end

   // angle units
   logic [31:0] root;
   logic [31:0] theta_raw, phi_raw;
   sb_type      sbm;
   logic [30:0] dy_mag;

   sscb_isqrt u_isqrt (
      .clock    (clock),
      .enable   (adv),
      .radicand ({1'b0, rho4_ff, 2'b00}),
      .root     (root)
   );

   assign sbm    = sb_ff[ISQRT_LAT-1];
   assign dy_mag = sbm.dy[30] ? 31'(-sbm.dy) : sbm.dy;

   sscb_cordic u_theta (
      .clock  (clock),
      .enable (adv),
      .x_in   ({{2{sbm.dx[30]}}, sbm.dx}),
      .y_in   ({2'b00, dy_mag}),
      .angle  (theta_raw)
   );

   sscb_cordic u_phi (
      .clock  (clock),
      .enable (adv),
      .x_in   ({sbm.dz[30], sbm.dz, 1'b0}),
      .y_in   ({1'b0, root}),
      .angle  (phi_raw)
   );

   // angle select and bin scaling
   sb_type      sbl;
   logic        g_vld_ff;
   logic [19:0] g_idx_ff;
   logic [31:0] g_theta_ff, g_phi_ff;
   logic [31:0] theta_sel, phi_sel;
   logic [42:0] az_prod, pol_prod;

   assign sbl = sb_ff[SB_LEN-1];

   always_comb begin
      if (sbl.dy == 31'd0) theta_sel = sbl.dx[30] ? ANGLE_HALF : 32'd0;
      else if (!sbl.dy[30]) theta_sel = theta_raw;
      else theta_sel = 32'd0 - theta_raw;
      if (sbl.rho_zero) phi_sel = sbl.dz[30] ? ANGLE_HALF : 32'd0;
      else phi_sel = phi_raw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_vld_ff <= 1'b0;
      end else if (adv) begin
         g_vld_ff <= sbv_ff[SB_LEN-1] && sbl.keep;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         g_idx_ff   <= sbl.idx;
         g_theta_ff <= theta_sel;
         g_phi_ff   <= phi_sel;
      end
   end

   assign az_prod  = {11'd0, g_theta_ff} * {32'd0, nt_ff};
   assign pol_prod = {11'd0, g_phi_ff} * {32'd0, np_ff};

   logic        rsp_valid_ff;
   logic [19:0] rsp_cell_ff;
   logic [9:0]  rsp_az_ff;
   logic [10:0] rsp_pol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= g_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_cell_ff <= g_idx_ff;
         rsp_az_ff   <= az_prod[41:32];
         rsp_pol_ff  <= pol_prod[41:31];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_shell_cell  = rsp_cell_ff;
   assign rsp_azimuth_bin = rsp_az_ff;
   assign rsp_polar_bin   = rsp_pol_ff;

endmodule

FILE: design/sscb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscb_checker
// Port-level checks on the binner's handshakes, bound to the top level.
// ----------------------------------------------------------------------------
module sscb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [19:0] rsp_shell_cell,
   input logic [9:0]  rsp_azimuth_bin,
   input logic [10:0] rsp_polar_bin
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_shell_cell)
         && $stable(rsp_azimuth_bin) && $stable(rsp_polar_bin))
      else $error("result changed during stall");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while output stalled");

   a_free_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty output");

endmodule

bind spherical_shell_cell_binner_unit sscb_checker u_sscb_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_shell_cell  (rsp_shell_cell),
   .rsp_azimuth_bin (rsp_azimuth_bin),
   .rsp_polar_bin   (rsp_polar_bin)
);
